@@ design/srp_pkg.sv @@
// Shared types and constants for the servo record/playback controller.
package srp_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADC_W   = 12;
  localparam int unsigned PULSE_W = 11;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned RPOS_W  = 10;
  localparam int unsigned CFG_W   = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAYBACK = 2'd2;

  // Pulse widths in microseconds
  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MID = 11'd1500;

  // ADC dead band: [DEAD_LOW, DEAD_HIGH)
  localparam logic [ADC_W-1:0] DEAD_LOW  = 12'd1948;
  localparam logic [ADC_W-1:0] DEAD_HIGH = 12'd2147;

  // Reset value of the record length register
  localparam logic [CFG_W-1:0] RECORD_LENGTH_RST = 11'd1000;

  // floor(x * 500 / d) as (x * ceil(500 * 2^S / d)) >> S, exact for x < 4096
  localparam int unsigned MAP_SHIFT = 24;
  localparam int unsigned MAP_K_W   = 24;
  localparam int unsigned MAP_Q_W   = 9;
  localparam logic [63:0] MAP_K_LOW_64 =
    ((64'd500 << MAP_SHIFT) + 64'd1946) / 64'd1947;
  localparam logic [63:0] MAP_K_HIGH_64 =
    ((64'd500 << MAP_SHIFT) + 64'd1947) / 64'd1948;
  localparam logic [MAP_K_W-1:0] MAP_K_LOW  = MAP_K_LOW_64[MAP_K_W-1:0];
  localparam logic [MAP_K_W-1:0] MAP_K_HIGH = MAP_K_HIGH_64[MAP_K_W-1:0];

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ADC_W-1:0] adc_sample;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic [MODE_W-1:0]  mode;
    logic [RPOS_W-1:0]  record_position;
  } out_t;

endpackage

@@ design/srp_store.sv @@
// Sample store: synchronous RAM with a high-water mark standing in for the clear.
module srp_store #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned AW          = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [srp_pkg::PULSE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [srp_pkg::PULSE_W-1:0] rd_data_o
);
  import srp_pkg::*;

  logic [PULSE_W-1:0] mem [STORE_DEPTH];
  logic [PULSE_W-1:0] rd_q;
  logic               hit_q;
  logic [AW:0]        hwm_q;
  logic [AW:0]        hwm_d;
  logic [AW:0]        wr_next;

  // Writes always start at entry 0 and climb by one, so the written
  // entries form a prefix; anything at or above the mark reads as zero.
  assign wr_next = {1'b0, wr_addr_i} + {{AW{1'b0}}, 1'b1};

  always_comb begin
    hwm_d = hwm_q;
    if (wr_en_i && (wr_next > hwm_q)) begin
      hwm_d = wr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwm_q <= '0;
    end else begin
      hwm_q <= hwm_d;
    end
  end

  // RAM array, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      hit_q <= ({1'b0, rd_addr_i} < hwm_q);
    end
  end

  assign rd_data_o = hit_q ? rd_q : '0;

endmodule

@@ design/servo_record_playback.sv @@
// Servo record/playback controller top level.
// An accepted transaction enters stage 1, then the output register once it is free.
// One transaction per cycle unless output stalls; at most one store read or write per item.
// A playback pulse comes from the store's registered read, resolved in the second stage.
// Reset: manual mode, pulse 1500, positions 0, record length 1000; the store
// needs no clearing pass (a high-water mark makes unwritten entries read as zero).
module servo_record_playback #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  srp_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output srp_pkg::out_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [srp_pkg::CFG_W-1:0] cfg_wdata_i
);
  import srp_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LW = ((AW + 1) > CFG_W) ? (AW + 1) : CFG_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

  // Configuration and architectural state
  logic [CFG_W-1:0]   rec_len_q;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [PULSE_W-1:0] pulse_q, pulse_d;
  logic [AW-1:0]      wpos_q, wpos_d;
  logic [AW-1:0]      rpos_q, rpos_d;

  // Second stage and output register
  logic               s1_valid_q;
  logic               s1_load_q;
  logic [MODE_W-1:0]  s1_mode_q;
  logic [AW-1:0]      s1_wpos_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               accept;
  logic               s1_adv;
  logic [LW-1:0]      len_raw, len_eff;
  logic [AW-1:0]      wpos_cur, rpos_cur;
  logic [AW:0]        wpos_inc, rpos_inc;
  logic               st_wr_en, st_rd_en;
  logic [PULSE_W-1:0] st_rd_data;
  logic [PULSE_W-1:0] s1_pulse;

  // ADC map signals
  logic                       adc_low, adc_dead;
  logic [ADC_W-1:0]           map_x;
  logic [MAP_K_W-1:0]         map_k;
  logic [ADC_W+MAP_K_W-1:0]   map_prod;
  logic [MAP_Q_W-1:0]         map_q;
  logic [PULSE_W-1:0]         map_pulse;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Effective record length: 0 acts as 1, clipped to the store depth
  always_comb begin
    len_raw = LW'(rec_len_q);
    len_eff = len_raw;
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > DEPTH_L) begin
      len_eff = DEPTH_L;
    end
  end

  // Positions wrap before the access if the length was lowered
  assign wpos_cur = (LW'(wpos_q) >= len_eff) ? '0 : wpos_q;
  assign rpos_cur = (LW'(rpos_q) >= len_eff) ? '0 : rpos_q;
  assign wpos_inc = {1'b0, wpos_cur} + {{AW{1'b0}}, 1'b1};
  assign rpos_inc = {1'b0, rpos_cur} + {{AW{1'b0}}, 1'b1};

  // ADC to pulse: dead band, else 1000/1500 plus an exact floored scale
  assign adc_low  = in_data_i.adc_sample < DEAD_LOW;
  assign adc_dead = !adc_low && (in_data_i.adc_sample < DEAD_HIGH);
  assign map_x    = adc_low ? in_data_i.adc_sample : (in_data_i.adc_sample - DEAD_HIGH);
  assign map_k    = adc_low ? MAP_K_LOW : MAP_K_HIGH;
  assign map_prod = ADC_W'(map_x) * MAP_K_W'(map_k);
  assign map_q    = map_prod[MAP_SHIFT +: MAP_Q_W];

  always_comb begin
    if (adc_dead) begin
      map_pulse = PULSE_MID;
    end else if (adc_low) begin
      map_pulse = PULSE_MIN + PULSE_W'(map_q);
    end else begin
      map_pulse = PULSE_MID + PULSE_W'(map_q);
    end
  end

  // Command decode at acceptance
  always_comb begin
    mode_d   = mode_q;
    wpos_d   = wpos_q;
    rpos_d   = rpos_q;
    st_wr_en = 1'b0;
    st_rd_en = 1'b0;
    if (accept) begin
      case (in_data_i.command)
        CMD_BUTTON: begin
          mode_d = (mode_q >= MODE_PLAYBACK) ? MODE_MANUAL : (mode_q + 2'd1);
          if (mode_d == MODE_RECORD) begin
            wpos_d = '0;
          end
        end
        CMD_TICK: begin
          if (mode_q == MODE_RECORD) begin
            st_wr_en = 1'b1;
            wpos_d   = (LW'(wpos_inc) >= len_eff) ? '0 : wpos_inc[AW-1:0];
          end else if (mode_q == MODE_PLAYBACK) begin
            st_rd_en = 1'b1;
            rpos_d   = (LW'(rpos_inc) >= len_eff) ? '0 : rpos_inc[AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Loaded pulse resolves in the second stage
  assign s1_pulse = s1_load_q ? st_rd_data : pulse_q;

  // Pulse register: ADC updates at acceptance, playback loads on leaving stage 1.
  // A playback load and a new ADC update never meet at one edge: the mode
  // is still playback for the item right behind a load.
  always_comb begin
    pulse_d = pulse_q;
    if (s1_adv && s1_load_q) begin
      pulse_d = st_rd_data;
    end
    if (accept && (in_data_i.command == CMD_SAMPLE) && (mode_q != MODE_PLAYBACK)) begin
      pulse_d = map_pulse;
    end
  end

  // Sample store
  srp_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (wpos_cur),
    .wr_data_i (pulse_q),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (rpos_cur),
    .rd_data_o (st_rd_data)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_len_q   <= RECORD_LENGTH_RST;
      mode_q      <= MODE_MANUAL;
      pulse_q     <= PULSE_MID;
      wpos_q      <= '0;
      rpos_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rec_len_q <= cfg_wdata_i;
      end
      mode_q  <= mode_d;
      pulse_q <= pulse_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_load_q <= st_rd_en;
      s1_mode_q <= mode_d;
      s1_wpos_q <= wpos_d;
    end
    if (s1_adv) begin
      out_q.pulse_width     <= s1_pulse;
      out_q.mode            <= s1_mode_q;
      out_q.record_position <= RPOS_W'(s1_wpos_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
